>>> hdl/cpt_pkg.sv
// shared indexes and operand tables for the closest point on triangle pipeline
`timescale 1ns / 1ps

package cpt_pkg;

   localparam int NCRD  = 3;
   localparam int NLANE = 3;

   // corner and query points
   localparam int NPT  = 4;
   localparam int PT_P = 0;
   localparam int PT_A = 1;
   localparam int PT_B = 2;
   localparam int PT_C = 3;

   // difference vectors
   localparam int NVEC = 7;
   localparam int V_AB = 0;
   localparam int V_AC = 1;
   localparam int V_AP = 2;
   localparam int V_BP = 3;
   localparam int V_CP = 4;
   localparam int V_BC = 5;
   localparam int V_CA = 6;

   // dot products
   localparam int NDOT = 11;
   localparam int D1   = 0;
   localparam int D2   = 1;
   localparam int D3   = 2;
   localparam int D4   = 3;
   localparam int D5   = 4;
   localparam int D6   = 5;
   localparam int DEN0 = 6;
   localparam int DEN1 = 7;
   localparam int DEN2 = 8;
   localparam int NUM1 = 9;
   localparam int NUM2 = 10;

   localparam int DOT_U [NDOT] = '{V_AB, V_AC, V_AB, V_AC, V_AB, V_AC,
                                   V_AB, V_BC, V_CA, V_BP, V_CP};
   localparam int DOT_V [NDOT] = '{V_AP, V_AP, V_BP, V_BP, V_CP, V_CP,
                                   V_AB, V_BC, V_CA, V_BC, V_CA};

   // flat triangle: edge i runs from EDGE_PT along EDGE_DIR
   localparam int EDGE_PT  [NLANE] = '{PT_A, PT_B, PT_C};
   localparam int EDGE_DIR [NLANE] = '{V_AB, V_BC, V_CA};
   localparam int EDGE_DEN [NLANE] = '{DEN0, DEN1, DEN2};
   localparam int EDGE_NUM [NLANE] = '{D1, NUM1, NUM2};

endpackage

>>> hdl/cpt_mul.sv
// two stage signed multiplier built from narrow partial products
`timescale 1ns / 1ps

module cpt_mul #(
   parameter int AW = 68,
   parameter int BW = 68,
   parameter int NA = 2,
   parameter int NB = 2
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [AW-1:0]    op_a,
   input  logic signed [BW-1:0]    op_b,
   output logic signed [AW+BW-1:0] prod
);

   localparam int AP = (AW + NA - 1) / NA;
   localparam int BP = (BW + NB - 1) / NB;
   localparam int PW = AW + BW;
   localparam int XW = AP + BP + 2;

   logic signed [NA*AP-1:0] ax;
   logic signed [NB*BP-1:0] bx;
   logic signed [AP:0]      pa [NA];
   logic signed [BP:0]      pb [NB];
   logic signed [XW-1:0]    pp_ff [NA*NB];
   logic signed [PW-1:0]    acc;
   logic signed [PW-1:0]    prod_ff;

   assign ax = (NA*AP)'(op_a);
   assign bx = (NB*BP)'(op_b);

   // top piece carries the sign, lower pieces are unsigned
   always_comb begin
      for (int i = 0; i < NA; i++) begin
         if (i == NA - 1) begin
            pa[i] = $signed({ax[i*AP+AP-1], ax[i*AP +: AP]});
         end else begin
            pa[i] = $signed({1'b0, ax[i*AP +: AP]});
         end
      end
      for (int j = 0; j < NB; j++) begin
         if (j == NB - 1) begin
            pb[j] = $signed({bx[j*BP+BP-1], bx[j*BP +: BP]});
         end else begin
            pb[j] = $signed({1'b0, bx[j*BP +: BP]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               pp_ff[i*NB+j] <= pa[i] * pb[j];
            end
         end
      end
   end

   always_comb begin
      acc = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            acc = acc + (PW'(pp_ff[i*NB+j]) <<< (i*AP + j*BP));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= acc;
      end
   end

   assign prod = prod_ff;

endmodule

>>> hdl/cpt_div.sv
// pipelined restoring divider, one quotient bit per stage, floor rounding
`timescale 1ns / 1ps

module cpt_div #(
   parameter int NW  = 176,
   parameter int DVW = 139,
   parameter int QW  = 34
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic                 num_neg,
   input  logic [NW-1:0]        num_mag,
   input  logic [DVW-1:0]       dvs,
   output logic signed [QW:0]   quo
);

   localparam int RW = (NW > DVW + QW) ? NW : DVW + QW;

   logic [RW-1:0]    rem_ff [QW+1];
   logic [DVW-1:0]   dvs_ff [QW+1];
   logic [QW-1:0]    quo_ff [QW+1];
   logic             neg_ff [QW+1];
   logic signed [QW:0] qs;
   logic signed [QW:0] res_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= RW'(num_mag);
         dvs_ff[0] <= dvs;
         quo_ff[0] <= '0;
         neg_ff[0] <= num_neg;
         for (int j = 1; j <= QW; j++) begin
            dvs_ff[j] <= dvs_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
            if (rem_ff[j-1] >= (RW'(dvs_ff[j-1]) << (QW - j))) begin
               rem_ff[j] <= rem_ff[j-1] - (RW'(dvs_ff[j-1]) << (QW - j));
               quo_ff[j] <= quo_ff[j-1] | (QW'(1) << (QW - j));
            end else begin
               rem_ff[j] <= rem_ff[j-1];
               quo_ff[j] <= quo_ff[j-1];
            end
         end
      end
   end

   assign qs = $signed({1'b0, quo_ff[QW]});

   // negative numerator: floor means one more when anything is left over
   always_ff @(posedge clock) begin
      if (en) begin
         if (neg_ff[QW]) begin
            res_ff <= -qs - $signed({{QW{1'b0}}, rem_ff[QW] != '0});
         end else begin
            res_ff <= qs;
         end
      end
   end

   assign quo = res_ff;

endmodule

>>> hdl/closest_point_on_triangle.sv
// closest point on a 3d triangle: one request per cycle while no result is held
// the divider's COORD_WIDTH+2 quotient stages set most of the depth, the rest
// are difference, product, region, rounding, distance and selection stages
// a stalled result holds every stage in place, nothing is dropped or repeated
// reset clears only the stage valid bits, datapath registers are not reset
`timescale 1ns / 1ps

module closest_point_on_triangle import cpt_pkg::*; #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_p_x,
   input  logic signed [COORD_WIDTH-1:0] req_p_y,
   input  logic signed [COORD_WIDTH-1:0] req_p_z,
   input  logic signed [COORD_WIDTH-1:0] req_a_x,
   input  logic signed [COORD_WIDTH-1:0] req_a_y,
   input  logic signed [COORD_WIDTH-1:0] req_a_z,
   input  logic signed [COORD_WIDTH-1:0] req_b_x,
   input  logic signed [COORD_WIDTH-1:0] req_b_y,
   input  logic signed [COORD_WIDTH-1:0] req_b_z,
   input  logic signed [COORD_WIDTH-1:0] req_c_x,
   input  logic signed [COORD_WIDTH-1:0] req_c_y,
   input  logic signed [COORD_WIDTH-1:0] req_c_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_q_x,
   output logic signed [COORD_WIDTH-1:0] rsp_q_y,
   output logic signed [COORD_WIDTH-1:0] rsp_q_z
);

   localparam int CW  = COORD_WIDTH;
   localparam int EW  = CW + 1;
   localparam int PW  = 2 * EW;
   localparam int DW  = PW + 2;
   localparam int VW  = 2 * DW + 1;
   localparam int SW  = VW + 2;
   localparam int MW  = SW + EW;
   localparam int NW  = MW + 3;
   localparam int QW  = CW + 2;
   localparam int XW  = QW + 2;
   localparam int GW  = XW + 1;
   localparam int HW  = 2 * GW + 2;
   localparam int NST = QW + 16;

   localparam int MUL_A [6] = '{D1, D3, D5, D1, D3, D5};
   localparam int MUL_B [6] = '{D4, D2, D2, D6, D6, D4};

   typedef struct packed {
      logic                                 degen;
      logic [NDOT-1:0][DW-1:0]              dot;
      logic [NVEC-1:0][NCRD-1:0][EW-1:0]    vec;
      logic [NPT-1:0][NCRD-1:0][CW-1:0]     pt;
   } ctx_type;

   typedef struct packed {
      logic [NCRD-1:0][CW-1:0] base;
      logic [SW-1:0]           s1;
      logic [SW-1:0]           s2;
      logic [SW-1:0]           den;
      logic [NCRD-1:0][EW-1:0] dir1;
      logic [NCRD-1:0][EW-1:0] dir2;
   } lane_type;

   typedef struct packed {
      logic                    degen;
      logic [NCRD-1:0][CW-1:0] p;
   } aux_type;

   typedef struct packed {
      aux_type                            aux;
      logic [NLANE-1:0][NCRD-1:0][CW-1:0] base;
   } car_type;

   logic            en;
   logic [NST-1:0]  vld_ff;

   logic signed [CW-1:0] pt_in     [NPT][NCRD];
   logic signed [EW-1:0] vec_s1_ff [NVEC][NCRD];
   logic signed [CW-1:0] pt_s1_ff  [NPT][NCRD];
   logic signed [PW-1:0] prd_s2_ff [NDOT][NCRD];
   logic signed [PW-1:0] crs_s2_ff [NCRD][2];
   logic signed [EW-1:0] vec_s2_ff [NVEC][NCRD];
   logic signed [CW-1:0] pt_s2_ff  [NPT][NCRD];

   ctx_type ctx_s3_in, ctx_s3_ff, ctx_s4_ff, ctx_s5_ff, ctx_s6_ff;

   logic signed [2*DW-1:0] vm [6];
   logic signed [VW-1:0]   va_s6_ff, vb_s6_ff, vc_s6_ff;
   logic signed [DW-1:0]   d1, d2, d3, d4, d5, d6, t1, t2;

   lane_type lane_in [NLANE];
   lane_type lane_s7_ff [NLANE];
   lane_type lane_s8_ff [NLANE];
   lane_type lane_s9_ff [NLANE];
   aux_type  aux_s7_ff, aux_s8_ff, aux_s9_ff;

   logic signed [MW-1:0] lm1 [NLANE][NCRD];
   logic signed [MW-1:0] lm2 [NLANE][NCRD];

   logic signed [NW-1:0] nn_in  [NLANE][NCRD];
   logic [SW-1:0]        dd_in  [NLANE];
   logic                 neg_s10_ff [NLANE][NCRD];
   logic [NW-1:0]        mag_s10_ff [NLANE][NCRD];
   logic [SW-1:0]        dvs_s10_ff [NLANE];
   car_type              car_s10_ff;
   car_type              car_dl_ff [QW+2];

   logic signed [QW:0]     quo [NLANE][NCRD];
   logic signed [XW-1:0]   x_fx_ff [NLANE][NCRD];
   aux_type                aux_fx_ff;
   logic signed [GW-1:0]   dvv [NLANE][NCRD];
   logic signed [2*GW-1:0] sq_ff [NLANE][NCRD];
   logic signed [XW-1:0]   x_sq_ff [NLANE][NCRD];
   aux_type                aux_sq_ff;
   logic [HW-1:0]          dist_ff [NLANE];
   logic signed [XW-1:0]   x_ds_ff [NLANE][NCRD];
   logic                   degen_ds_ff;
   logic [1:0]             best;
   logic signed [CW-1:0]   q_in [NCRD];
   logic signed [CW-1:0]   q_ff [NCRD];

   // whole pipe advances unless the finished result is held
   assign en        = !(vld_ff[NST-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = vld_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], req_valid};
      end
   end

   assign pt_in[PT_P][0] = req_p_x;
   assign pt_in[PT_P][1] = req_p_y;
   assign pt_in[PT_P][2] = req_p_z;
   assign pt_in[PT_A][0] = req_a_x;
   assign pt_in[PT_A][1] = req_a_y;
   assign pt_in[PT_A][2] = req_a_z;
   assign pt_in[PT_B][0] = req_b_x;
   assign pt_in[PT_B][1] = req_b_y;
   assign pt_in[PT_B][2] = req_b_z;
   assign pt_in[PT_C][0] = req_c_x;
   assign pt_in[PT_C][1] = req_c_y;
   assign pt_in[PT_C][2] = req_c_z;

   // edge and offset vectors
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NCRD; k++) begin
            vec_s1_ff[V_AB][k] <= EW'(pt_in[PT_B][k]) - EW'(pt_in[PT_A][k]);
            vec_s1_ff[V_AC][k] <= EW'(pt_in[PT_C][k]) - EW'(pt_in[PT_A][k]);
            vec_s1_ff[V_AP][k] <= EW'(pt_in[PT_P][k]) - EW'(pt_in[PT_A][k]);
            vec_s1_ff[V_BP][k] <= EW'(pt_in[PT_P][k]) - EW'(pt_in[PT_B][k]);
            vec_s1_ff[V_CP][k] <= EW'(pt_in[PT_P][k]) - EW'(pt_in[PT_C][k]);
            vec_s1_ff[V_BC][k] <= EW'(pt_in[PT_C][k]) - EW'(pt_in[PT_B][k]);
            vec_s1_ff[V_CA][k] <= EW'(pt_in[PT_A][k]) - EW'(pt_in[PT_C][k]);
         end
         pt_s1_ff <= pt_in;
      end
   end

   // per coordinate products for dots and the normal
   always_ff @(posedge clock) begin
      if (en) begin
         for (int d = 0; d < NDOT; d++) begin
            for (int k = 0; k < NCRD; k++) begin
               prd_s2_ff[d][k] <= vec_s1_ff[DOT_U[d]][k] * vec_s1_ff[DOT_V[d]][k];
            end
         end
         for (int k = 0; k < NCRD; k++) begin
            crs_s2_ff[k][0] <= vec_s1_ff[V_AB][(k+1)%3] * vec_s1_ff[V_AC][(k+2)%3];
            crs_s2_ff[k][1] <= vec_s1_ff[V_AB][(k+2)%3] * vec_s1_ff[V_AC][(k+1)%3];
         end
         vec_s2_ff <= vec_s1_ff;
         pt_s2_ff  <= pt_s1_ff;
      end
   end

   always_comb begin
      ctx_s3_in.degen = 1'b1;
      for (int k = 0; k < NCRD; k++) begin
         if (crs_s2_ff[k][0] != crs_s2_ff[k][1]) begin
            ctx_s3_in.degen = 1'b0;
         end
      end
      for (int d = 0; d < NDOT; d++) begin
         ctx_s3_in.dot[d] = DW'(prd_s2_ff[d][0]) + DW'(prd_s2_ff[d][1])
                          + DW'(prd_s2_ff[d][2]);
      end
      for (int v = 0; v < NVEC; v++) begin
         for (int k = 0; k < NCRD; k++) begin
            ctx_s3_in.vec[v][k] = vec_s2_ff[v][k];
         end
      end
      for (int i = 0; i < NPT; i++) begin
         for (int k = 0; k < NCRD; k++) begin
            ctx_s3_in.pt[i][k] = pt_s2_ff[i][k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctx_s3_ff <= ctx_s3_in;
         ctx_s4_ff <= ctx_s3_ff;
         ctx_s5_ff <= ctx_s4_ff;
         ctx_s6_ff <= ctx_s5_ff;
      end
   end

   // products of dots for the barycentric weights
   for (genvar g = 0; g < 6; g++) begin : g_vmul
      cpt_mul #(.AW(DW), .BW(DW), .NA(2), .NB(2)) u_mul (
         .clock (clock),
         .en    (en),
         .op_a  ($signed(ctx_s3_ff.dot[MUL_A[g]])),
         .op_b  ($signed(ctx_s3_ff.dot[MUL_B[g]])),
         .prod  (vm[g])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vc_s6_ff <= VW'(vm[0]) - VW'(vm[1]);
         vb_s6_ff <= VW'(vm[2]) - VW'(vm[3]);
         va_s6_ff <= VW'(vm[4]) - VW'(vm[5]);
      end
   end

   assign d1 = $signed(ctx_s6_ff.dot[D1]);
   assign d2 = $signed(ctx_s6_ff.dot[D2]);
   assign d3 = $signed(ctx_s6_ff.dot[D3]);
   assign d4 = $signed(ctx_s6_ff.dot[D4]);
   assign d5 = $signed(ctx_s6_ff.dot[D5]);
   assign d6 = $signed(ctx_s6_ff.dot[D6]);
   assign t1 = d4 - d3;
   assign t2 = d5 - d6;

   // region choice; each lane becomes base + (s1*dir1 + s2*dir2) / den
   always_comb begin
      logic signed [DW-1:0] enu;
      logic signed [DW-1:0] eden;
      enu  = '0;
      eden = '0;
      for (int l = 0; l < NLANE; l++) begin
         lane_in[l].base = ctx_s6_ff.pt[PT_A];
         lane_in[l].s1   = '0;
         lane_in[l].s2   = '0;
         lane_in[l].den  = SW'(1);
         lane_in[l].dir1 = ctx_s6_ff.vec[V_AB];
         lane_in[l].dir2 = ctx_s6_ff.vec[V_AC];
      end
      if (ctx_s6_ff.degen) begin
         // flat triangle: clamped projection onto each edge
         for (int l = 0; l < NLANE; l++) begin
            eden = $signed(ctx_s6_ff.dot[EDGE_DEN[l]]);
            enu  = $signed(ctx_s6_ff.dot[EDGE_NUM[l]]);
            if (enu < 0) begin
               enu = '0;
            end else if (enu > eden) begin
               enu = eden;
            end
            lane_in[l].base = ctx_s6_ff.pt[EDGE_PT[l]];
            lane_in[l].s1   = SW'(enu);
            lane_in[l].den  = SW'(eden);
            lane_in[l].dir1 = ctx_s6_ff.vec[EDGE_DIR[l]];
         end
      end else begin
         priority if (d1 <= 0 && d2 <= 0) begin
            lane_in[0].base = ctx_s6_ff.pt[PT_A];
         end else if (d3 >= 0 && d4 <= d3) begin
            lane_in[0].base = ctx_s6_ff.pt[PT_B];
         end else if (vc_s6_ff <= 0 && d1 >= 0 && d3 <= 0) begin
            lane_in[0].s1  = SW'(d1);
            lane_in[0].den = SW'(d1 - d3);
         end else if (d6 >= 0 && d5 <= d6) begin
            lane_in[0].base = ctx_s6_ff.pt[PT_C];
         end else if (vb_s6_ff <= 0 && d2 >= 0 && d6 <= 0) begin
            lane_in[0].s1   = SW'(d2);
            lane_in[0].dir1 = ctx_s6_ff.vec[V_AC];
            lane_in[0].den  = SW'(d2 - d6);
         end else if (va_s6_ff <= 0 && t1 >= 0 && t2 >= 0) begin
            lane_in[0].base = ctx_s6_ff.pt[PT_B];
            lane_in[0].s1   = SW'(t1);
            lane_in[0].dir1 = ctx_s6_ff.vec[V_BC];
            lane_in[0].den  = SW'(t1) + SW'(t2);
         end else begin
            lane_in[0].s1  = SW'(vb_s6_ff);
            lane_in[0].s2  = SW'(vc_s6_ff);
            lane_in[0].den = SW'(va_s6_ff) + SW'(vb_s6_ff) + SW'(vc_s6_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_s7_ff      <= lane_in;
         lane_s8_ff      <= lane_s7_ff;
         lane_s9_ff      <= lane_s8_ff;
         aux_s7_ff.degen <= ctx_s6_ff.degen;
         aux_s7_ff.p     <= ctx_s6_ff.pt[PT_P];
         aux_s8_ff       <= aux_s7_ff;
         aux_s9_ff       <= aux_s8_ff;
      end
   end

   for (genvar l = 0; l < NLANE; l++) begin : g_lane
      for (genvar k = 0; k < NCRD; k++) begin : g_crd
         cpt_mul #(.AW(SW), .BW(EW), .NA(4), .NB(1)) u_mul1 (
            .clock (clock),
            .en    (en),
            .op_a  ($signed(lane_s7_ff[l].s1)),
            .op_b  ($signed(lane_s7_ff[l].dir1[k])),
            .prod  (lm1[l][k])
         );
         cpt_mul #(.AW(SW), .BW(EW), .NA(4), .NB(1)) u_mul2 (
            .clock (clock),
            .en    (en),
            .op_a  ($signed(lane_s7_ff[l].s2)),
            .op_b  ($signed(lane_s7_ff[l].dir2[k])),
            .prod  (lm2[l][k])
         );
         cpt_div #(.NW(NW), .DVW(SW), .QW(QW)) u_div (
            .clock   (clock),
            .en      (en),
            .num_neg (neg_s10_ff[l][k]),
            .num_mag (mag_s10_ff[l][k]),
            .dvs     (dvs_s10_ff[l]),
            .quo     (quo[l][k])
         );
      end
   end

   // round to nearest: floor((2n + d) / 2d); a divisor that is not positive gives zero
   always_comb begin
      for (int l = 0; l < NLANE; l++) begin
         if ($signed(lane_s9_ff[l].den) <= 0) begin
            dd_in[l] = SW'(2);
         end else begin
            dd_in[l] = lane_s9_ff[l].den << 1;
         end
         for (int k = 0; k < NCRD; k++) begin
            if ($signed(lane_s9_ff[l].den) <= 0) begin
               nn_in[l][k] = NW'(1);
            end else begin
               nn_in[l][k] = ((NW'(lm1[l][k]) + NW'(lm2[l][k])) <<< 1)
                           + NW'($signed(lane_s9_ff[l].den));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < NLANE; l++) begin
            dvs_s10_ff[l] <= dd_in[l];
            for (int k = 0; k < NCRD; k++) begin
               neg_s10_ff[l][k] <= nn_in[l][k][NW-1];
               mag_s10_ff[l][k] <= nn_in[l][k][NW-1] ? -nn_in[l][k] : nn_in[l][k];
            end
            car_s10_ff.base[l] <= lane_s9_ff[l].base;
         end
         car_s10_ff.aux <= aux_s9_ff;
         car_dl_ff[0]   <= car_s10_ff;
         for (int i = 1; i < QW + 2; i++) begin
            car_dl_ff[i] <= car_dl_ff[i-1];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < NLANE; l++) begin
         for (int k = 0; k < NCRD; k++) begin
            dvv[l][k] = GW'($signed(aux_fx_ff.p[k])) - GW'(x_fx_ff[l][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < NLANE; l++) begin
            for (int k = 0; k < NCRD; k++) begin
               x_fx_ff[l][k] <= XW'($signed(car_dl_ff[QW+1].base[l][k])) + XW'(quo[l][k]);
               sq_ff[l][k]   <= dvv[l][k] * dvv[l][k];
            end
            dist_ff[l] <= HW'(sq_ff[l][0]) + HW'(sq_ff[l][1]) + HW'(sq_ff[l][2]);
         end
         aux_fx_ff   <= car_dl_ff[QW+1].aux;
         x_sq_ff     <= x_fx_ff;
         aux_sq_ff   <= aux_fx_ff;
         x_ds_ff     <= x_sq_ff;
         degen_ds_ff <= aux_sq_ff.degen;
      end
   end

   // for a flat triangle the nearest edge wins, earlier edge on a tie; then clamp to the coordinate range
   always_comb begin
      best = 2'd0;
      if (degen_ds_ff) begin
         if (dist_ff[1] < dist_ff[0]) begin
            best = 2'd1;
         end
         if (dist_ff[2] < dist_ff[best]) begin
            best = 2'd2;
         end
      end
      for (int k = 0; k < NCRD; k++) begin
         if (x_ds_ff[best][k][XW-1:CW-1] == '0 || x_ds_ff[best][k][XW-1:CW-1] == '1) begin
            q_in[k] = x_ds_ff[best][k][CW-1:0];
         end else if (x_ds_ff[best][k][XW-1]) begin
            q_in[k] = $signed({1'b1, {(CW-1){1'b0}}});
         end else begin
            q_in[k] = $signed({1'b0, {(CW-1){1'b1}}});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= q_in;
      end
   end

   assign rsp_q_x = q_ff[0];
   assign rsp_q_y = q_ff[1];
   assign rsp_q_z = q_ff[2];

endmodule

>>> hdl/cpt_check.sv
// port level checks for the closest point on triangle block
`timescale 1ns / 1ps

module cpt_check #(
   parameter int COORD_WIDTH = 32
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [COORD_WIDTH-1:0] rsp_q_x,
   input logic signed [COORD_WIDTH-1:0] rsp_q_y,
   input logic signed [COORD_WIDTH-1:0] rsp_q_z
);

   // the input side only stalls behind a held result
   a_stall_cause: assert property (@(posedge clock)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a held result");

   // a held result always backs up into the request side
   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("held result not pushed back");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_q_x) && $stable(rsp_q_y) && $stable(rsp_q_z)))
      else $error("stalled result changed");

endmodule

bind closest_point_on_triangle cpt_check #(.COORD_WIDTH(COORD_WIDTH)) u_cpt_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_q_x   (rsp_q_x),
   .rsp_q_y   (rsp_q_y),
   .rsp_q_z   (rsp_q_z)
);

>>> tb/tb.sv
// testbench for the closest point on triangle block: queued driver, monitor, exact predictor
`timescale 1ns / 1ps

module tb;

   localparam int CW = 32;
   localparam int LAT = 50;
   localparam int MAX_CYCLES = 400000;

   typedef logic signed [CW-1:0] crd_type;
   typedef logic signed [255:0] wide_type;
   typedef struct packed { crd_type x, y, z; } pnt_type;
   typedef struct packed { pnt_type p, a, b, c; } query_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   crd_type req_p_x = 0, req_p_y = 0, req_p_z = 0;
   crd_type req_a_x = 0, req_a_y = 0, req_a_z = 0;
   crd_type req_b_x = 0, req_b_y = 0, req_b_z = 0;
   crd_type req_c_x = 0, req_c_y = 0, req_c_z = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   crd_type rsp_q_x, rsp_q_y, rsp_q_z;

   closest_point_on_triangle #(.COORD_WIDTH(CW)) dut (.*);

   always #10 clock = ~clock;

   query_type pending[$];
   pnt_type nearest_q[$];
   int errors = 0;
   int sent = 0;
   int got = 0;
   int cycles = 0;
   bit hold_rsp = 0;
   int hold_len = 0;

   // exact arithmetic on wide signed vectors
   function automatic wide_type dot(wide_type u[3], wide_type v[3]);
      return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
   endfunction

   // floor division for positive divisor
   function automatic wide_type fdiv(wide_type n, wide_type d);
      wide_type q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
   endfunction

   function automatic wide_type rnd_div(wide_type n, wide_type d);
      if (d <= 0) return 0;
      return fdiv(2 * n + d, 2 * d);
   endfunction

   function automatic crd_type sat(wide_type v);
      if (v > wide_type'(32'sh7fffffff)) return 32'sh7fffffff;
      if (v < -wide_type'(33'sh080000000)) return 32'sh80000000;
      return v[CW-1:0];
   endfunction

   function automatic pnt_type nearest_point(query_type q);
      wide_type p[3], a[3], b[3], c[3], ab[3], ac[3], ap[3], bp[3], cp[3], bc[3];
      wide_type r[3], v[3][3], e[3], x[3], dv[3];
      wide_type n0, n1, n2, d1, d2, d3, d4, d5, d6, va, vb, vc, t1, t2, den, num, dsq, best;
      pnt_type res;
      int k, i;
      p = '{q.p.x, q.p.y, q.p.z};
      a = '{q.a.x, q.a.y, q.a.z};
      b = '{q.b.x, q.b.y, q.b.z};
      c = '{q.c.x, q.c.y, q.c.z};
      for (k = 0; k < 3; k++) begin
         ab[k] = b[k] - a[k]; ac[k] = c[k] - a[k]; ap[k] = p[k] - a[k];
         bp[k] = p[k] - b[k]; cp[k] = p[k] - c[k]; bc[k] = c[k] - b[k];
      end
      n0 = ab[1] * ac[2] - ab[2] * ac[1];
      n1 = ab[2] * ac[0] - ab[0] * ac[2];
      n2 = ab[0] * ac[1] - ab[1] * ac[0];
      if (n0 == 0 && n1 == 0 && n2 == 0) begin
         // flat triangle: clamped projection on each edge, earlier edge wins ties
         v[0] = a; v[1] = b; v[2] = c;
         best = 0;
         r = a;
         for (i = 0; i < 3; i++) begin
            for (k = 0; k < 3; k++) begin
               e[k] = v[(i + 1) % 3][k] - v[i][k];
               dv[k] = p[k] - v[i][k];
            end
            x = v[i];
            den = dot(e, e);
            if (den > 0) begin
               num = dot(dv, e);
               if (num < 0) num = 0;
               if (num > den) num = den;
               for (k = 0; k < 3; k++) x[k] = v[i][k] + rnd_div(num * e[k], den);
            end
            for (k = 0; k < 3; k++) dv[k] = p[k] - x[k];
            dsq = dot(dv, dv);
            if (i == 0 || dsq < best) begin
               r = x; best = dsq;
            end
         end
      end else begin
         d1 = dot(ab, ap); d2 = dot(ac, ap);
         d3 = dot(ab, bp); d4 = dot(ac, bp);
         d5 = dot(ab, cp); d6 = dot(ac, cp);
         vc = d1 * d4 - d3 * d2;
         vb = d5 * d2 - d1 * d6;
         va = d3 * d6 - d5 * d4;
         t1 = d4 - d3; t2 = d5 - d6;
         if (d1 <= 0 && d2 <= 0) r = a;
         else if (d3 >= 0 && d4 <= d3) r = b;
         else if (vc <= 0 && d1 >= 0 && d3 <= 0)
            for (k = 0; k < 3; k++) r[k] = a[k] + rnd_div(d1 * ab[k], d1 - d3);
         else if (d6 >= 0 && d5 <= d6) r = c;
         else if (vb <= 0 && d2 >= 0 && d6 <= 0)
            for (k = 0; k < 3; k++) r[k] = a[k] + rnd_div(d2 * ac[k], d2 - d6);
         else if (va <= 0 && t1 >= 0 && t2 >= 0)
            for (k = 0; k < 3; k++) r[k] = b[k] + rnd_div(t1 * bc[k], t1 + t2);
         else begin
            den = va + vb + vc;
            for (k = 0; k < 3; k++)
               r[k] = a[k] + rnd_div(vb * ab[k] + vc * ac[k], den);
         end
      end
      res.x = sat(r[0]); res.y = sat(r[1]); res.z = sat(r[2]);
      return res;
   endfunction

   function automatic crd_type rnd_crd(int scale);
      unique case ($urandom_range(0, 9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $urandom;
         default: return crd_type'($signed($urandom_range(0, 2 * scale)) - scale);
      endcase
   endfunction

   function automatic pnt_type rnd_pnt(int scale);
      pnt_type r;
      r.x = rnd_crd(scale); r.y = rnd_crd(scale); r.z = rnd_crd(scale);
      return r;
   endfunction

   function automatic query_type rnd_query();
      query_type q;
      int scale;
      int t;
      scale = 1 << $urandom_range(4, 24);
      q.p = rnd_pnt(scale);
      q.a = rnd_pnt(scale);
      q.b = rnd_pnt(scale);
      q.c = rnd_pnt(scale);
      t = $urandom_range(0, 9);
      // flat shapes: collinear, repeated corners, single point
      if (t == 0) begin
         q.c.x = q.a.x + 2 * (q.b.x - q.a.x);
         q.c.y = q.a.y + 2 * (q.b.y - q.a.y);
         q.c.z = q.a.z + 2 * (q.b.z - q.a.z);
      end else if (t == 1) q.b = q.a;
      else if (t == 2) begin q.b = q.a; q.c = q.a; end
      else if (t == 3) q.c = q.b;
      return q;
   endfunction

   // append a request to the driver's list
   function automatic void enqueue(query_type q);
      pending.insert(pending.size(), q);
   endfunction

   // driver
   int gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            nearest_q.insert(nearest_q.size(), nearest_point({req_p_x, req_p_y, req_p_z,
               req_a_x, req_a_y, req_a_z, req_b_x, req_b_y, req_b_z, req_c_x, req_c_y,
               req_c_z}));
            sent++;
         end
         if (gap > 0) begin
            gap <= gap - 1;
            req_valid <= 0;
         end else if (pending.size() > 0) begin
            query_type q;
            q = pending.pop_front();
            req_valid <= 1;
            {req_p_x, req_p_y, req_p_z, req_a_x, req_a_y, req_a_z,
             req_b_x, req_b_y, req_b_z, req_c_x, req_c_y, req_c_z} <= q;
            gap <= (sent % 300 < 100) ? 0 : $urandom_range(0, 6);
         end else begin
            req_valid <= 0;
         end
      end
   end

   // monitor and receiver stalls
   int rgap = 0;
   always @(posedge clock) begin
      pnt_type e;
      cycles++;
      if (cycles > MAX_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got++;
         if (nearest_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result %h %h %h", $time, rsp_q_x, rsp_q_y, rsp_q_z);
         end else begin
            e = nearest_q.pop_front();
            if (e.x !== rsp_q_x) begin
               errors++;
               $display("%0t: q_x expected %h actual %h", $time, e.x, rsp_q_x);
            end
            if (e.y !== rsp_q_y) begin
               errors++;
               $display("%0t: q_y expected %h actual %h", $time, e.y, rsp_q_y);
            end
            if (e.z !== rsp_q_z) begin
               errors++;
               $display("%0t: q_z expected %h actual %h", $time, e.z, rsp_q_z);
            end
         end
      end
      if (hold_len > 0) begin
         hold_len <= hold_len - 1;
         rsp_stall <= 1;
      end else if (hold_rsp) begin
         hold_rsp <= 0;
         hold_len <= 300;
         rsp_stall <= 1;
      end else if (rgap > 0) begin
         rgap <= rgap - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
         rgap <= (got % 400 < 150) ? 0 : $urandom_range(0, 6);
      end
   end

   task automatic add_dir(pnt_type p, pnt_type a, pnt_type b, pnt_type c);
      query_type q;
      q.p = p; q.a = a; q.b = b; q.c = c;
      enqueue(q);
   endtask

   function automatic pnt_type pt(int x, int y, int z);
      pnt_type r;
      r.x = x <<< 16; r.y = y <<< 16; r.z = z <<< 16;
      return r;
   endfunction

   task automatic drain();
      while (pending.size() > 0 || req_valid || nearest_q.size() > 0) @(posedge clock);
   endtask

   pnt_type mx, mn;
   initial begin
      mx = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
      mn = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
      repeat (6) @(posedge clock);
      reset <= 0;
      // vertex, edge and face regions of a right triangle
      add_dir(pt(-1, -1, 0), pt(0, 0, 0), pt(4, 0, 0), pt(0, 4, 0));
      add_dir(pt(6, -1, 0), pt(0, 0, 0), pt(4, 0, 0), pt(0, 4, 0));
      add_dir(pt(2, -3, 1), pt(0, 0, 0), pt(4, 0, 0), pt(0, 4, 0));
      add_dir(pt(-1, 7, 0), pt(0, 0, 0), pt(4, 0, 0), pt(0, 4, 0));
      add_dir(pt(-3, 2, 5), pt(0, 0, 0), pt(4, 0, 0), pt(0, 4, 0));
      add_dir(pt(3, 3, -2), pt(0, 0, 0), pt(4, 0, 0), pt(0, 4, 0));
      add_dir(pt(1, 1, 9), pt(0, 0, 0), pt(4, 0, 0), pt(0, 4, 0));
      add_dir('{32'sd1, 32'sd1, 32'sd7}, '{0, 0, 0}, '{32'sd3, 0, 0}, '{0, 32'sd3, 0});
      // flat: collinear, repeated corner, single point, tie between edges
      add_dir(pt(1, 5, 0), pt(0, 0, 0), pt(2, 0, 0), pt(4, 0, 0));
      add_dir(pt(7, 2, 2), pt(1, 1, 1), pt(1, 1, 1), pt(3, 3, 3));
      add_dir(pt(5, 5, 5), pt(1, 2, 3), pt(1, 2, 3), pt(1, 2, 3));
      add_dir(pt(2, 3, 0), pt(0, 0, 0), pt(4, 0, 0), pt(0, 0, 0));
      // coordinate extremes
      add_dir(mx, mn, mx, mn);
      add_dir(mn, mx, mn, mx);
      add_dir(mx, mn, '{32'sh7fffffff, 32'sh80000000, 0}, '{0, 32'sh7fffffff, 32'sh80000000});
      add_dir(mn, mn, mx, '{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff});
      add_dir('{32'sh7fffffff, 0, 32'sh80000000}, mx, '{0, 0, 0}, mn);
      drain();
      for (int i = 0; i < 1100; i++) begin
         enqueue(rnd_query());
         if (i == 500) begin
            // long receiver hold while the sender keeps offering
            hold_rsp <= 1;
            while (pending.size() > 0) @(posedge clock);
         end
         if (i == 800) drain();
      end
      drain();
      repeat (LAT * 2) @(posedge clock);
      $display("covered %0d requests: vertex, edge, face and flat triangles", sent);
      $display("coordinate extremes, random stalls and one long output hold; %0d mismatches",
               errors);
      if (errors == 0 && nearest_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
